// File: hw/rtl/utf8v_pkg.sv
package utf8v_pkg;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        CLS_PLAIN = 3'd0,
        CLS_E0    = 3'd1,
        CLS_ED    = 3'd2,
        CLS_F0    = 3'd3,
        CLS_F4    = 3'd4
    } byte_class_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// File: hw/rtl/utf8v_in_if.sv
interface utf8v_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// File: hw/rtl/utf8v_out_if.sv
interface utf8v_out_if;
    logic valid;
    logic ready;
    logic text_valid;

    modport source (output valid, output text_valid, input ready);
    modport sink (input valid, input text_valid, output ready);
endinterface

// File: hw/rtl/utf8_text_validator_unit.sv
// An end marker's verdict passes through the input register and then the output register before it is offered.
// Throughput: one item per cycle while no end marker is held back; byte items never wait on the output side.
// An end marker waits in the input register only while the previous verdict is unread.
// Reset: rst_n is asynchronous and active low; it empties both registers and clears
// the per-text state, so the next byte starts a new text.
module utf8_text_validator_unit (
    input logic         clk,
    input logic         rst_n,
    utf8v_in_if.sink    text_in,
    utf8v_out_if.source verdict_out
);

    utf8v_pkg::stage_t stage;
    logic              advance;
    logic              out_free;
    logic              verdict;
    logic              load_out;

    assign advance  = stage.valid
                      && ((stage.item.kind == utf8v_pkg::KIND_BYTE) || out_free);
    assign load_out = advance && (stage.item.kind == utf8v_pkg::KIND_END);

    utf8v_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .src     (text_in),
        .advance (advance),
        .stage   (stage)
    );

    utf8v_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (stage.item),
        .fire    (advance),
        .verdict (verdict)
    );

    utf8v_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load_out),
        .verdict (verdict),
        .free    (out_free),
        .dst     (verdict_out)
    );

endmodule

// File: hw/rtl/utf8v_in_stage.sv
module utf8v_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    utf8v_in_if.sink          src,
    input  logic              advance,
    output utf8v_pkg::stage_t stage
);

    logic              valid_reg;
    logic              valid_next;
    utf8v_pkg::item_t  item_reg;
    logic              take;

    assign src.ready = !valid_reg || advance;
    assign take      = src.valid && src.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind      <= src.kind;
            item_reg.data_byte <= src.data_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: hw/rtl/utf8v_checker.sv
module utf8v_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  utf8v_pkg::item_t item,
    input  logic             fire,
    output logic             verdict
);

    logic [1:0]             pend_reg;
    logic [1:0]             pend_next;
    utf8v_pkg::byte_class_t cls_reg;
    utf8v_pkg::byte_class_t cls_next;
    logic                   err_reg;
    logic                   err_next;
    logic                   nonempty_reg;
    logic                   nonempty_next;
    logic                   cont_ok;
    logic [7:0]             b;

    assign b = item.data_byte;

    always_comb
    begin
        case (cls_reg)
            utf8v_pkg::CLS_E0: cont_ok = (b >= 8'ha0) && (b <= 8'hbf);
            utf8v_pkg::CLS_ED: cont_ok = (b >= 8'h80) && (b <= 8'h9f);
            utf8v_pkg::CLS_F0: cont_ok = (b >= 8'h90) && (b <= 8'hbf);
            utf8v_pkg::CLS_F4: cont_ok = (b >= 8'h80) && (b <= 8'h8f);
            default:           cont_ok = (b >= 8'h80) && (b <= 8'hbf);
        endcase
    end

    always_comb
    begin
        pend_next     = pend_reg;
        cls_next      = cls_reg;
        err_next      = err_reg;
        nonempty_next = nonempty_reg;
        if (fire)
        begin
            if (item.kind == utf8v_pkg::KIND_END)
            begin
                pend_next     = 2'd0;
                cls_next      = utf8v_pkg::CLS_PLAIN;
                err_next      = 1'b0;
                nonempty_next = 1'b0;
            end
            else
            begin
                nonempty_next = 1'b1;
                if (!err_reg)
                begin
                    if (pend_reg != 2'd0)
                    begin
                        if (cont_ok)
                        begin
                            pend_next = pend_reg - 2'd1;
                            cls_next  = utf8v_pkg::CLS_PLAIN;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cls_next = utf8v_pkg::CLS_PLAIN;
                        if (b == 8'h00)
                        begin
                            err_next = 1'b1;
                        end
                        else if (b <= 8'h7f)
                        begin
                            pend_next = 2'd0;
                        end
                        else if ((b >= 8'hc2) && (b <= 8'hdf))
                        begin
                            pend_next = 2'd1;
                        end
                        else if (b == 8'he0)
                        begin
                            pend_next = 2'd2;
                            cls_next  = utf8v_pkg::CLS_E0;
                        end
                        else if (b == 8'hed)
                        begin
                            pend_next = 2'd2;
                            cls_next  = utf8v_pkg::CLS_ED;
                        end
                        else if ((b >= 8'he1) && (b <= 8'hef))
                        begin
                            pend_next = 2'd2;
                        end
                        else if (b == 8'hf0)
                        begin
                            pend_next = 2'd3;
                            cls_next  = utf8v_pkg::CLS_F0;
                        end
                        else if (b == 8'hf4)
                        begin
                            pend_next = 2'd3;
                            cls_next  = utf8v_pkg::CLS_F4;
                        end
                        else if ((b >= 8'hf1) && (b <= 8'hf3))
                        begin
                            pend_next = 2'd3;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 2'd0;
            cls_reg      <= utf8v_pkg::CLS_PLAIN;
            err_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
        end
        else
        begin
            pend_reg     <= pend_next;
            cls_reg      <= cls_next;
            err_reg      <= err_next;
            nonempty_reg <= nonempty_next;
        end
    end

    assign verdict = nonempty_reg && !err_reg && (pend_reg == 2'd0);

endmodule

// File: hw/rtl/utf8v_out_stage.sv
module utf8v_out_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        verdict,
    output logic        free,
    utf8v_out_if.source dst
);

    logic valid_reg;
    logic valid_next;
    logic data_reg;

    assign free = !valid_reg || dst.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (dst.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= verdict;
        end
    end

    assign dst.valid      = valid_reg;
    assign dst.text_valid = data_reg;

endmodule
